[rtl/first_fit_heap_allocator_assert.svh]
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffha assertion failed");
`define FFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_NOW(label, ante, cons)
`define FFHA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/ffha_pkg.sv]
package ffha_pkg;

  localparam int HeapBytesDef    = 4096;
  localparam int HeaderBytesDef  = 16;
  localparam int EndMarkBytesDef = 16;

  localparam int LenW    = 13;
  localparam int BaddrW  = 12;
  localparam int PaddrW  = 12;
  localparam int CntW    = 13;
  localparam int BlkW    = 12;
  localparam int SplitW  = 13;
  localparam int SizeW   = 18;
  localparam int SumW    = SizeW + 1;

  localparam logic [SplitW-1:0] MinSplitRst = SplitW'(16);

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  localparam logic StDone    = 1'b0;
  localparam logic StRefused = 1'b1;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             alloc;
  } hdr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WRITE2,
    S_FREE_HEAD,
    S_FREE_NEXT
  } state_e;

endpackage

[rtl/first_fit_heap_allocator.sv]
// channel   direction  handshake                     word
// request   in         start & !busy                 req_type, request_bytes, block_address
// result    out        done_o, one cycle, no stall   status, payload_address, counts
// config    in         cfg_valid_i & cfg_ready_o     min_split_bytes
//
// zero length, or free address below the header size or outside the heap: result in the cycle after acceptance
// allocate: the first-fit walk does one memory read per header visited, and S_WRITE2
//   follows when an extend or in-heap split writes a second header
// free: head read and write past the end of the heap, else head read, next read, write
// reset leaves the header memory uncleared; only the end marker at offset zero
//   is flagged, so requests are taken straight after reset
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES     = ffha_pkg::HeapBytesDef,
  parameter int HEADER_BYTES   = ffha_pkg::HeaderBytesDef,
  parameter int END_MARK_BYTES = ffha_pkg::EndMarkBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [ffha_pkg::LenW-1:0]   request_bytes_i,
  input  logic [ffha_pkg::BaddrW-1:0] block_address_i,
  output logic                        done_o,
  output logic                        status_o,
  output logic [ffha_pkg::PaddrW-1:0] payload_address_o,
  output logic [ffha_pkg::CntW-1:0]   free_bytes_o,
  output logic [ffha_pkg::CntW-1:0]   allocated_bytes_o,
  output logic [ffha_pkg::BlkW-1:0]   allocated_blocks_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ffha_pkg::SplitW-1:0] cfg_wdata_i
);
  import ffha_pkg::*;

  `include "first_fit_heap_allocator_assert.svh"

  localparam int AddrW = $clog2(HEAP_BYTES);
  localparam logic [SumW-1:0] HeapSum = SumW'(HEAP_BYTES);
  localparam logic [SumW-1:0] HdrSum  = SumW'(HEADER_BYTES);
  localparam logic [SumW-1:0] EndSum  = SumW'(END_MARK_BYTES);

  hdr_t mem [HEAP_BYTES];

  state_e            state_q, state_d;
  logic [AddrW-1:0]  off_q, off_d;
  logic [SizeW-1:0]  need_q, need_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic [AddrW-1:0]  w2_addr_q, w2_addr_d;
  hdr_t              w2_data_q, w2_data_d;
  logic [CntW-1:0]   free_q, free_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [BlkW-1:0]   blk_q, blk_d;
  logic              done_q, done_d;
  logic              status_q, status_d;
  logic [PaddrW-1:0] paddr_q, paddr_d;
  logic [SplitW-1:0] min_split_q;
  logic              init_q, init_d;
  logic              rd_init_q;
  hdr_t              rd_q;
  hdr_t              rd_hdr;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  hdr_t              mem_wdata;

  logic [SumW-1:0]   step_sum, need_sum, head_sum, paddr_sum, rem_sum;

  assign rd_hdr = rd_init_q ? '{size: '0, alloc: 1'b1} : rd_q;

  assign step_sum  = SumW'(off_q) + SumW'(rd_hdr.size);
  assign rem_sum   = SumW'(off_q) + SumW'(need_q);
  assign paddr_sum = SumW'(off_q) + HdrSum;
  assign need_sum  = (SumW'(request_bytes_i) + SumW'(1) + HdrSum) & ~SumW'(1);
  assign head_sum  = SumW'(block_address_i) - HdrSum;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    off_d     = off_q;
    need_d    = need_q;
    size_d    = size_q;
    w2_addr_d = w2_addr_q;
    w2_data_d = w2_data_q;
    free_d    = free_q;
    used_d    = used_q;
    blk_d     = blk_q;
    done_d    = 1'b0;
    status_d  = status_q;
    paddr_d   = paddr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = off_q;
    mem_raddr = off_q;
    mem_wdata = '{size: need_q, alloc: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          paddr_d = '0;
          if (req_type_i == ReqAlloc) begin
            if (request_bytes_i == '0) begin
              done_d   = 1'b1;
              status_d = StRefused;
            end else begin
              need_d    = need_sum[SizeW-1:0];
              off_d     = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = S_WALK;
            end
          end else begin
            if (SumW'(block_address_i) < HdrSum || SumW'(block_address_i) >= HeapSum) begin
              done_d   = 1'b1;
              status_d = StRefused;
            end else begin
              off_d     = head_sum[AddrW-1:0];
              mem_re    = 1'b1;
              mem_raddr = head_sum[AddrW-1:0];
              state_d   = S_FREE_HEAD;
            end
          end
        end
      end

      S_WALK: begin
        if (rd_hdr.size == '0) begin
          // end marker: extend if the block and a new marker fit
          if (rem_sum + EndSum > HeapSum) begin
            done_d   = 1'b1;
            status_d = StRefused;
            state_d  = S_IDLE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = rem_sum[AddrW-1:0];
            mem_wdata = '{size: '0, alloc: 1'b1};
            w2_addr_d = off_q;
            w2_data_d = '{size: need_q, alloc: 1'b1};
            used_d    = used_q + need_q[CntW-1:0];
            free_d    = free_q - need_q[CntW-1:0];
            blk_d     = blk_q + BlkW'(1);
            paddr_d   = paddr_sum[PaddrW-1:0];
            state_d   = S_WRITE2;
          end
        end else if (!rd_hdr.alloc && rd_hdr.size >= need_q) begin
          blk_d   = blk_q + BlkW'(1);
          paddr_d = paddr_sum[PaddrW-1:0];
          mem_we  = 1'b1;
          if (SumW'(need_q) + SumW'(min_split_q) < SumW'(rd_hdr.size)) begin
            // split, remainder header stays free
            mem_wdata = '{size: need_q, alloc: 1'b1};
            used_d    = used_q + need_q[CntW-1:0];
            free_d    = free_q - need_q[CntW-1:0];
            w2_addr_d = rem_sum[AddrW-1:0];
            w2_data_d = '{size: rd_hdr.size - need_q, alloc: 1'b0};
            if (rem_sum < HeapSum) begin
              state_d = S_WRITE2;
            end else begin
              done_d   = 1'b1;
              status_d = StDone;
              state_d  = S_IDLE;
            end
          end else begin
            mem_wdata = '{size: rd_hdr.size, alloc: 1'b1};
            used_d    = used_q + rd_hdr.size[CntW-1:0];
            free_d    = free_q - rd_hdr.size[CntW-1:0];
            done_d    = 1'b1;
            status_d  = StDone;
            state_d   = S_IDLE;
          end
        end else if (step_sum >= HeapSum) begin
          done_d   = 1'b1;
          status_d = StRefused;
          state_d  = S_IDLE;
        end else begin
          off_d     = step_sum[AddrW-1:0];
          mem_re    = 1'b1;
          mem_raddr = step_sum[AddrW-1:0];
        end
      end

      S_WRITE2: begin
        mem_we    = 1'b1;
        mem_waddr = w2_addr_q;
        mem_wdata = w2_data_q;
        done_d    = 1'b1;
        status_d  = StDone;
        state_d   = S_IDLE;
      end

      S_FREE_HEAD: begin
        size_d = rd_hdr.size;
        used_d = used_q - rd_hdr.size[CntW-1:0];
        free_d = free_q + rd_hdr.size[CntW-1:0];
        blk_d  = blk_q - BlkW'(1);
        if (step_sum < HeapSum) begin
          mem_re    = 1'b1;
          mem_raddr = step_sum[AddrW-1:0];
          state_d   = S_FREE_NEXT;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = '{size: rd_hdr.size, alloc: 1'b0};
          done_d    = 1'b1;
          status_d  = StDone;
          state_d   = S_IDLE;
        end
      end

      S_FREE_NEXT: begin
        // a zero-size head reads itself as next, already seen as free
        mem_we = 1'b1;
        if (!rd_hdr.alloc || size_q == '0) begin
          mem_wdata = '{size: size_q + rd_hdr.size, alloc: 1'b0};
        end else begin
          mem_wdata = '{size: size_q, alloc: 1'b0};
        end
        done_d   = 1'b1;
        status_d = StDone;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    init_d = init_q && !(mem_we && mem_waddr == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= CntW'(HEAP_BYTES);
      used_q      <= '0;
      blk_q       <= '0;
      done_q      <= 1'b0;
      min_split_q <= MinSplitRst;
      init_q      <= 1'b1;
      rd_init_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      used_q  <= used_d;
      blk_q   <= blk_d;
      done_q  <= done_d;
      init_q  <= init_d;
      if (mem_re) begin
        rd_init_q <= init_q && (mem_raddr == '0);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        min_split_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q     <= off_d;
    need_q    <= need_d;
    size_q    <= size_d;
    w2_addr_q <= w2_addr_d;
    w2_data_q <= w2_data_d;
    status_q  <= status_d;
    paddr_q   <= paddr_d;
  end

  // header memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign payload_address_o  = paddr_q;
  assign free_bytes_o       = free_q;
  assign allocated_bytes_o  = used_q;
  assign allocated_blocks_o = blk_q;

  `FFHA_ASSERT_NOW(a_done_idle, done_o, !busy)
  `FFHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o)
  `FFHA_ASSERT_NOW(a_refuse_no_addr, done_o && status_o == StRefused, payload_address_o == '0)
  `FFHA_ASSERT_NEXT(a_write2_done, state_q == S_WRITE2, done_o && status_o == StDone)

endmodule

[verif/heap_allocation_checker.sv]
module heap_allocation_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        req_type_i,
  input  logic [ffha_pkg::LenW-1:0]   request_bytes_i,
  input  logic [ffha_pkg::BaddrW-1:0] block_address_i,
  input  logic                        done_o,
  input  logic                        status_o,
  input  logic [ffha_pkg::PaddrW-1:0] payload_address_o,
  input  logic [ffha_pkg::CntW-1:0]   free_bytes_o,
  input  logic [ffha_pkg::CntW-1:0]   allocated_bytes_o,
  input  logic [ffha_pkg::BlkW-1:0]   allocated_blocks_o,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [ffha_pkg::SplitW-1:0] cfg_wdata_i,
  output int                          fail_count_o,
  output int                          outstanding_o
);
  import ffha_pkg::*;

  localparam int unsigned HeapBytes = HeapBytesDef;
  localparam int unsigned HdrBytes  = HeaderBytesDef;
  localparam int unsigned EndBytes  = EndMarkBytesDef;

  typedef struct packed {
    logic              status;
    logic [PaddrW-1:0] payload;
    logic [CntW-1:0]   free_bytes;
    logic [CntW-1:0]   used_bytes;
    logic [BlkW-1:0]   blocks;
  } result_word_t;

  logic [SizeW-1:0] block_size [HeapBytes];
  logic             block_used [HeapBytes];
  logic [CntW-1:0]  free_total;
  logic [CntW-1:0]  used_total;
  logic [BlkW-1:0]  block_total;
  logic [SplitW-1:0] split_margin;
  result_word_t     pending_results [$];
  int               fails = 0;

  task automatic write_header(input int unsigned off, input int unsigned size, input logic used);
    if (off < HeapBytes) begin
      block_size[off] = SizeW'(size);
      block_used[off] = used;
    end
  endtask

  task automatic take_bytes(input int unsigned bytes);
    used_total  = used_total + CntW'(bytes);
    free_total  = free_total - CntW'(bytes);
    block_total = block_total + 1'b1;
  endtask

  task automatic apply_heap_request(input logic rt, input logic [LenW-1:0] len,
                                    input logic [BaddrW-1:0] baddr,
                                    output result_word_t word);
    int unsigned need;
    int unsigned off;
    int unsigned size;
    int unsigned head;
    int unsigned nxt;
    bit          searching;
    logic        refused;
    logic [PaddrW-1:0] grant;
    refused = 1'b0;
    grant = '0;
    size = 0;
    if (rt == ReqAlloc) begin
      if (len == '0) begin
        refused = 1'b1;
      end else begin
        need = (32'(len) + 1 + HdrBytes) & ~32'd1;
        off = 0;
        searching = 1'b1;
        // first fit: stop at the end marker or a free block big enough
        while (searching) begin
          if (off >= HeapBytes) begin
            refused = 1'b1;
            searching = 1'b0;
          end else begin
            size = block_size[off];
            if (size == 0 || (!block_used[off] && size >= need)) searching = 1'b0;
            else off = off + size;
          end
        end
        if (!refused) begin
          if (size == 0) begin
            if (off + need + EndBytes > HeapBytes) begin
              refused = 1'b1;
            end else begin
              write_header(off + need, 0, 1'b1);
              write_header(off, need, 1'b1);
              take_bytes(need);
            end
          end else if (need + split_margin < size) begin
            write_header(off, need, 1'b1);
            write_header(off + need, size - need, 1'b0);
            take_bytes(need);
          end else begin
            write_header(off, size, 1'b1);
            take_bytes(size);
          end
          if (!refused) grant = PaddrW'(off + HdrBytes);
        end
      end
    end else if (32'(baddr) < HdrBytes || 32'(baddr) >= HeapBytes) begin
      refused = 1'b1;
    end else begin
      head = 32'(baddr) - HdrBytes;
      size = block_size[head];
      used_total  = used_total - CntW'(size);
      free_total  = free_total + CntW'(size);
      block_total = block_total - 1'b1;
      block_used[head] = 1'b0;
      // merge forward only
      nxt = head + size;
      if (nxt < HeapBytes && !block_used[nxt]) block_size[head] = SizeW'(size + block_size[nxt]);
    end
    word.status     = refused ? StRefused : StDone;
    word.payload    = grant;
    word.free_bytes = free_total;
    word.used_bytes = used_total;
    word.blocks     = block_total;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t want;
    result_word_t next_word;
    if (!rst_ni) begin
      for (int i = 0; i < HeapBytes; i++) begin
        block_size[i] = '0;
        block_used[i] = 1'b0;
      end
      block_used[0] = 1'b1;
      free_total   = CntW'(HeapBytes);
      used_total   = '0;
      block_total  = '0;
      split_margin = MinSplitRst;
      pending_results.delete();
      outstanding_o <= 0;
      fail_count_o  <= fails;
    end else begin
      if (done_o !== 1'b0) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing outstanding, status %0d payload %0d",
                   $time, status_o, payload_address_o);
          fails++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, status_o);
          compare_field("payload_address", want.payload, payload_address_o);
          compare_field("free_bytes", want.free_bytes, free_bytes_o);
          compare_field("allocated_bytes", want.used_bytes, allocated_bytes_o);
          compare_field("allocated_blocks", want.blocks, allocated_blocks_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) split_margin = cfg_wdata_i;
      if (start && !busy) begin
        apply_heap_request(req_type_i, request_bytes_i, block_address_i, next_word);
        pending_results.push_back(next_word);
      end
      outstanding_o <= pending_results.size();
      fail_count_o  <= fails;
    end
  end

endmodule

[verif/testbench.sv]
module testbench;
  import ffha_pkg::*;

  localparam int HdrBytes      = HeaderBytesDef;
  localparam int ItemsPerPhase = 155;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type_i = ReqAlloc;
  logic [LenW-1:0]   request_bytes_i = '0;
  logic [BaddrW-1:0] block_address_i = '0;
  logic              done_o;
  logic              status_o;
  logic [PaddrW-1:0] payload_address_o;
  logic [CntW-1:0]   free_bytes_o;
  logic [CntW-1:0]   allocated_bytes_o;
  logic [BlkW-1:0]   allocated_blocks_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SplitW-1:0] cfg_wdata_i = MinSplitRst;
  int                fail_count;
  int                outstanding;
  bit                no_idle = 1'b0;
  logic [BaddrW-1:0] live_payloads [$];
  logic [BaddrW-1:0] granted_payloads [$];
  bit                known_payload [int];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  first_fit_heap_allocator uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .free_bytes_o      (free_bytes_o),
    .allocated_bytes_o (allocated_bytes_o),
    .allocated_blocks_o(allocated_blocks_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  heap_allocation_checker allocation_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .free_bytes_o      (free_bytes_o),
    .allocated_bytes_o (allocated_bytes_o),
    .allocated_blocks_o(allocated_blocks_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_wdata_i       (cfg_wdata_i),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding)
  );

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // granted payloads, sampled mid-cycle so the request side sees them race-free
  always @(negedge clk_i) begin
    if (rst_ni && done_o === 1'b1 && status_o == StDone && payload_address_o != '0) begin
      live_payloads.push_back(payload_address_o);
      if (!known_payload.exists(int'(payload_address_o))) begin
        known_payload[int'(payload_address_o)] = 1'b1;
        granted_payloads.push_back(payload_address_o);
      end
    end
  end

  task automatic issue(input logic rt, input logic [LenW-1:0] len, input logic [BaddrW-1:0] ba);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= rt;
    request_bytes_i <= len;
    block_address_i <= ba;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic allocate(input int len);
    issue(ReqAlloc, LenW'(len), BaddrW'($urandom_range(0, 4095)));
  endtask

  task automatic free_block(input int addr);
    issue(ReqFree, LenW'($urandom_range(0, 4096)), BaddrW'(addr));
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy !== 1'b0);
  endtask

  task automatic write_split_margin(input int margin);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= SplitW'(margin);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 64);
    if (r < 92) return $urandom_range(65, 400);
    return $urandom_range(401, 4096);
  endfunction

  task automatic random_request();
    int pick;
    int idx;
    if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
    if ($urandom_range(0, 59) == 0) settle();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      allocate(random_length());
    end else if (pick < 90 && live_payloads.size() > 0) begin
      idx = $urandom_range(0, live_payloads.size() - 1);
      free_block(live_payloads[idx]);
      live_payloads.delete(idx);
    end else if (pick < 93 && granted_payloads.size() > 0) begin
      free_block(granted_payloads[$urandom_range(0, granted_payloads.size() - 1)]);
    end else if (pick < 96) begin
      free_block($urandom_range(0, HdrBytes - 1));
    end else if (pick < 98) begin
      allocate(0);
    end else begin
      allocate($urandom_range(2048, 4096));
    end
  endtask

  initial begin
    int margins [6];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refusals first, then a small chain with merge, split and whole-block reuse
    allocate(0);
    free_block(0);
    free_block(HdrBytes - 1);
    allocate(4096);
    allocate(1);
    allocate(100);
    allocate(200);
    allocate(8);
    free_block(HdrBytes + 134);
    free_block(HdrBytes + 18);
    free_block(HdrBytes + 18);
    allocate(50);
    allocate(248);
    // run the end marker up to the heap end
    allocate(3000);
    allocate(700);
    allocate(670);
    free_block(HdrBytes + 4076);
    allocate(1);
    free_block(HdrBytes + 3390);
    free_block(HdrBytes + 374);
    settle();
    live_payloads.delete();

    margins[0] = 0;
    margins[1] = 4096;
    margins[2] = 4095;
    margins[3] = $urandom_range(1, 64);
    margins[4] = $urandom_range(0, 4096);
    margins[5] = MinSplitRst;
    foreach (margins[p]) begin
      write_split_margin(margins[p]);
      repeat (ItemsPerPhase) random_request();
      settle();
    end

    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
